// ===== hdl/mqttpp_pkg.sv =====
// Shared types and constants for the MQTT PUBLISH frame parser.
package mqttpp_pkg;

  // Parse phase, ordered so that body phases compare above PH_TLEN
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_PID     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_PAST    = 3'd6
  } phase_t;

  // Role code of a rejected byte
  localparam logic [2:0] ROLE_REJECT = 3'd7;

  // Header checks
  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] PUBLISH_TYPE = 8'h30;
  localparam logic [1:0] QOS_MASK     = 2'h3;

  // Length field
  localparam logic [6:0] GROUP_MASK   = 7'h7F;
  localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

  // Smallest buffer that can hold a frame
  localparam int unsigned MIN_BUFFER = 4;

  // Fixed offsets inside a frame
  localparam logic [3:0] TOPIC_BASE = 4'd3;

  // One input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  byte_role;
    logic        verdict_valid;
    logic        accepted;
    logic        qos_level;
    logic [15:0] topic_offset;
    logic [15:0] topic_length;
    logic [15:0] packet_identifier;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

endpackage

// ===== hdl/mqttpp_core.sv =====
// Per-byte parse state and the combinational step that gives each byte's result.
module mqttpp_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mqttpp_pkg::item_t  item,
  output mqttpp_pkg::result_t result
);

  localparam logic [COUNT_WIDTH-1:0] MaxCount = '1;

  // Parse state
  mqttpp_pkg::phase_t        parse_phase, parse_phase_next;
  logic [COUNT_WIDTH-1:0]    bytes_seen, bytes_seen_next;
  logic [27:0]               length_accum, length_accum_next;
  logic [2:0]                length_bytes, length_bytes_next;
  logic [COUNT_WIDTH-1:0]    frame_limit, frame_limit_next;
  logic [15:0]               topic_bytes, topic_bytes_next;
  logic [15:0]               packet_id_store, packet_id_store_next;
  logic                      qos_store, qos_store_next;
  logic                      reject_flag, reject_flag_next;
  logic [COUNT_WIDTH-1:0]    payload_start, payload_start_next;

  // Step intermediates
  logic [7:0]                b;
  logic [COUNT_WIDTH-1:0]    pos;
  logic [2:0]                role;
  logic [27:0]               group;
  logic [28:0]               fe;
  logic [3:0]                ts;
  logic [17:0]               topic_end;
  logic [17:0]               ps;
  logic [15:0]               tl;
  logic                      ok;

  always_comb begin
    b   = item.rx_byte;
    pos = bytes_seen;

    parse_phase_next     = parse_phase;
    bytes_seen_next      = bytes_seen;
    length_accum_next    = length_accum;
    length_bytes_next    = length_bytes;
    frame_limit_next     = frame_limit;
    topic_bytes_next     = topic_bytes;
    packet_id_store_next = packet_id_store;
    qos_store_next       = qos_store;
    reject_flag_next     = reject_flag | (bytes_seen == MaxCount);
    payload_start_next   = payload_start;

    role      = 3'(mqttpp_pkg::PH_HEADER);
    group     = '0;
    fe        = '0;
    tl        = '0;
    ts        = mqttpp_pkg::TOPIC_BASE + 4'(length_bytes);
    topic_end = 18'(ts) + 18'(topic_bytes);
    ps        = '0;

    // Advance the phase for this byte
    if (!reject_flag_next) begin
      unique case (parse_phase)
        mqttpp_pkg::PH_HEADER: begin
          role = 3'(mqttpp_pkg::PH_HEADER);
          if ((b & mqttpp_pkg::TYPE_MASK) != mqttpp_pkg::PUBLISH_TYPE ||
              (b[2:1] & mqttpp_pkg::QOS_MASK) > 2'd1) begin
            reject_flag_next = 1'b1;
          end else begin
            qos_store_next   = b[1];
            parse_phase_next = mqttpp_pkg::PH_LENGTH;
          end
        end
        mqttpp_pkg::PH_LENGTH: begin
          role = 3'(mqttpp_pkg::PH_LENGTH);
          unique case (length_bytes[1:0])
            2'd0: group = {21'd0, b[6:0] & mqttpp_pkg::GROUP_MASK};
            2'd1: group = {14'd0, b[6:0] & mqttpp_pkg::GROUP_MASK, 7'd0};
            2'd2: group = {7'd0, b[6:0] & mqttpp_pkg::GROUP_MASK, 14'd0};
            default: group = {b[6:0] & mqttpp_pkg::GROUP_MASK, 21'd0};
          endcase
          length_accum_next = length_accum | group;
          length_bytes_next = length_bytes + 3'd1;
          fe = 29'd1 + 29'(length_bytes_next) + 29'(length_accum_next);
          if (b[7]) begin
            if (length_bytes_next >= mqttpp_pkg::MAX_LEN_BYTES) begin
              reject_flag_next = 1'b1;
            end
          end else if (fe > 29'(MaxCount) ||
                       29'(mqttpp_pkg::TOPIC_BASE) + 29'(length_bytes_next) > fe) begin
            reject_flag_next = 1'b1;
          end else begin
            frame_limit_next = COUNT_WIDTH'(fe);
            parse_phase_next = mqttpp_pkg::PH_TLEN;
          end
        end
        mqttpp_pkg::PH_TLEN: begin
          role = 3'(mqttpp_pkg::PH_TLEN);
          if ((COUNT_WIDTH+1)'(pos) == (COUNT_WIDTH+1)'(length_bytes) + 1'b1) begin
            topic_bytes_next = {b, 8'd0};
          end else begin
            tl = topic_bytes | {8'd0, b};
            topic_bytes_next = tl;
            ps = 18'(ts) + 18'(tl) + 18'({qos_store, 1'b0});
            if (18'(ts) + 18'(tl) > 18'(frame_limit) || ps > 18'(frame_limit)) begin
              reject_flag_next = 1'b1;
            end else begin
              payload_start_next = COUNT_WIDTH'(ps);
              parse_phase_next   = mqttpp_pkg::PH_TOPIC;
            end
          end
        end
        default: begin
          // Place the byte by the known frame layout
          if (18'(pos) < topic_end) begin
            parse_phase_next = mqttpp_pkg::PH_TOPIC;
          end else if (pos < payload_start) begin
            parse_phase_next = mqttpp_pkg::PH_PID;
          end else if (pos < frame_limit) begin
            parse_phase_next = mqttpp_pkg::PH_PAYLOAD;
          end else begin
            parse_phase_next = mqttpp_pkg::PH_PAST;
          end
          role = 3'(parse_phase_next);
          if (parse_phase_next == mqttpp_pkg::PH_PID) begin
            if ((COUNT_WIDTH+1)'(pos) + 2'd2 == (COUNT_WIDTH+1)'(payload_start)) begin
              packet_id_store_next = {b, 8'd0};
            end else begin
              packet_id_store_next = packet_id_store | {8'd0, b};
            end
          end
        end
      endcase
    end
    if (reject_flag_next) role = mqttpp_pkg::ROLE_REJECT;

    // Count the byte, saturating
    if (bytes_seen < MaxCount) bytes_seen_next = bytes_seen + 1'b1;

    // Build the verdict on the final byte
    ok = !reject_flag_next &&
         bytes_seen_next >= COUNT_WIDTH'(mqttpp_pkg::MIN_BUFFER) &&
         parse_phase_next >= mqttpp_pkg::PH_TOPIC &&
         frame_limit_next <= bytes_seen_next;

    result = '0;
    if (item.buffer_end) begin
      result.verdict_valid = 1'b1;
      if (ok) begin
        result.accepted          = 1'b1;
        result.qos_level         = qos_store_next;
        result.topic_offset      = 16'(ts);
        result.topic_length      = topic_bytes_next;
        result.packet_identifier = qos_store_next ? packet_id_store_next : 16'd0;
        result.payload_offset    = 16'(payload_start_next);
        result.payload_length    = 16'(frame_limit_next - payload_start_next);
      end else begin
        role = mqttpp_pkg::ROLE_REJECT;
      end
    end
    result.byte_role = role;
  end

  // Hold or advance the state; rearm after the final byte
  always_ff @(posedge clk) begin
    if (rst || (step && item.buffer_end)) begin
      parse_phase     <= mqttpp_pkg::PH_HEADER;
      bytes_seen      <= '0;
      length_accum    <= '0;
      length_bytes    <= '0;
      frame_limit     <= '0;
      topic_bytes     <= '0;
      packet_id_store <= '0;
      qos_store       <= 1'b0;
      reject_flag     <= 1'b0;
      payload_start   <= '0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      bytes_seen      <= bytes_seen_next;
      length_accum    <= length_accum_next;
      length_bytes    <= length_bytes_next;
      frame_limit     <= frame_limit_next;
      topic_bytes     <= topic_bytes_next;
      packet_id_store <= packet_id_store_next;
      qos_store       <= qos_store_next;
      reject_flag     <= reject_flag_next;
      payload_start   <= payload_start_next;
    end
  end

endmodule

// ===== hdl/mqtt_publish_frame_parser_unit.sv =====
// Top level: input register, parse step and result register of the PUBLISH parser.
// Each accepted input beat passes the input register, then the result register.
// Throughput: one byte per cycle while out_stall is low, via the combinational parse
// step between them; the input register can take a beat while a result waits.
// Reset: synchronous rst clears both registers' valid flags and all parse state;
// the parser also rearms itself after every final byte.
module mqtt_publish_frame_parser_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_role,
  output logic        verdict_valid,
  output logic        accepted,
  output logic        qos_level,
  output logic [15:0] topic_offset,
  output logic [15:0] topic_length,
  output logic [15:0] packet_identifier,
  output logic [15:0] payload_offset,
  output logic [15:0] payload_length
);

  logic                in_full;
  mqttpp_pkg::item_t   in_item;
  logic                move;
  logic                take;
  mqttpp_pkg::result_t step_result;
  mqttpp_pkg::result_t out_result;

  // Move the held beat forward when the result register frees up
  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;
  assign take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.rx_byte    <= rx_byte;
      in_item.buffer_end <= buffer_end;
    end
  end

  mqttpp_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (move),
    .item   (in_item),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_result <= step_result;
    end
  end

  assign byte_role         = out_result.byte_role;
  assign verdict_valid     = out_result.verdict_valid;
  assign accepted          = out_result.accepted;
  assign qos_level         = out_result.qos_level;
  assign topic_offset      = out_result.topic_offset;
  assign topic_length      = out_result.topic_length;
  assign packet_identifier = out_result.packet_identifier;
  assign payload_offset    = out_result.payload_offset;
  assign payload_length    = out_result.payload_length;

endmodule
